// File: rtl/lowkz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowkz_pkg
// Shared constants, types and ring arithmetic for the longest-window block.
// ----------------------------------------------------------------------------
package lowkz_pkg;

  localparam int unsigned ZERO_RING_DEPTH = 256;
  localparam int unsigned POSITION_BITS   = 20;
  localparam int unsigned CFG_BITS        = 8;
  localparam int unsigned RING_AW         = (ZERO_RING_DEPTH > 1) ? $clog2(ZERO_RING_DEPTH) : 1;
  localparam int unsigned ZCNT_W          = RING_AW + 1;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [RING_AW-1:0]       ring_idx_t;
  typedef logic [RING_AW:0]         ring_ext_t;
  typedef logic [ZCNT_W-1:0]        zcnt_t;
  typedef logic [CFG_BITS-1:0]      cfg_t;

  // Zero limit in use: the register value, saturated at ring depth minus one.
  function automatic ring_idx_t sat_limit(input cfg_t m);
    if (32'(m) > 32'(ZERO_RING_DEPTH - 1)) begin
      return ring_idx_t'(ZERO_RING_DEPTH - 1);
    end else begin
      return ring_idx_t'(m);
    end
  endfunction

  function automatic ring_idx_t ring_next(input ring_idx_t head);
    if (head == ring_idx_t'(ZERO_RING_DEPTH - 1)) begin
      return '0;
    end else begin
      return head + 1'b1;
    end
  endfunction

  // head - n, modulo the ring depth (n < depth)
  function automatic ring_idx_t ring_back(input ring_idx_t head, input ring_idx_t n);
    ring_ext_t diff;
    diff = {1'b0, head} - {1'b0, n};
    if (diff[RING_AW]) begin
      diff = diff + ring_ext_t'(ZERO_RING_DEPTH);
    end
    return diff[RING_AW-1:0];
  endfunction

endpackage

// File: rtl/lowkz_bit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowkz_bit_if
// Input channel: one string bit per item, with last-bit marker.
// ----------------------------------------------------------------------------
interface lowkz_bit_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic last_bit;

  modport source (output valid, output bit_value, output last_bit, input ready);
  modport sink   (input valid, input bit_value, input last_bit, output ready);
endinterface

// File: rtl/lowkz_win_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowkz_win_if
// Output channel: best window of one string.
// ----------------------------------------------------------------------------
interface lowkz_win_if
  import lowkz_pkg::*;
;
  logic valid;
  logic ready;
  logic found;
  pos_t window_start;
  pos_t window_end;

  modport source (output valid, output found, output window_start, output window_end,
                  input ready);
  modport sink   (input valid, input found, input window_start, input window_end,
                  output ready);
endinterface

// File: rtl/lowkz_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowkz_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lowkz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/longest_ones_window_k_zeros_top.sv
`timescale 1ns / 1ps
// Result: registered in the output register as the last bit of a string is accepted.
// Throughput: one bit per cycle while the output slot is free or being drained; the
//   oldest-zero position is prefetched through the single registered RAM read port.
// Reset: asynchronous, active low; clears max_zeros and all string state. The ring RAM
//   is not cleared (no clearing pass); only entries written in the current string are used.
// ----------------------------------------------------------------------------
// longest_ones_window_k_zeros_top
// Longest window of a bit string holding at most max_zeros zero bits.
// ----------------------------------------------------------------------------
module longest_ones_window_k_zeros_top
  import lowkz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  cfg_t               cfg_wdata_i,
  lowkz_bit_if.sink          bit_i,
  lowkz_win_if.source        win_o
);

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  cfg_t      max_zeros_q, max_zeros_d;
  ring_idx_t head_q, head_d;         // next ring slot to write
  zcnt_t     zeros_q, zeros_d;       // zero bits inside current window
  pos_t      cur_start_q, cur_start_d;
  pos_t      pos_cnt_q, pos_cnt_d;   // bits seen in this string
  pos_t      best_start_q, best_start_d;
  pos_t      best_len_q, best_len_d;

  // Forwarding of a write that hit the prefetch address in the same cycle
  logic      fwd_q, fwd_d;
  pos_t      fwd_data_q;

  // Output register
  logic      out_valid_q, out_valid_d;
  logic      out_found_q, out_found_d;
  pos_t      out_start_q, out_start_d;
  pos_t      out_end_q, out_end_d;

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  ring_idx_t limit;      // limit in force this cycle
  ring_idx_t limit_nx;   // limit in force next cycle (prefetch address)
  logic      in_fire;
  logic      is_zero;
  pos_t      pos;
  zcnt_t     zc_inc;
  logic      overflow;
  pos_t      ram_rdata;
  pos_t      oldest;     // zero position that leaves the window
  zcnt_t     zeros_new;
  pos_t      start_new;
  pos_t      len;
  logic      take_best;
  pos_t      best_start_new;
  pos_t      best_len_new;
  ring_idx_t raddr;

  assign limit    = sat_limit(max_zeros_q);
  assign limit_nx = sat_limit(cfg_we_i ? cfg_wdata_i : max_zeros_q);

  // Output register parts the two sides; a bit is taken whenever the
  // result slot is free or being drained.
  assign bit_i.ready = !out_valid_q || win_o.ready;
  assign in_fire     = bit_i.valid && bit_i.ready;
  assign is_zero     = in_fire && !bit_i.bit_value;

  assign pos      = pos_cnt_q + 1'b1;
  assign zc_inc   = zeros_q + 1'b1;
  assign overflow = zc_inc > zcnt_t'(limit);

  // Limit of zero: the leaving zero is the one written this cycle.
  // Limit of one: the prefetch read collided with last cycle's write.
  always_comb begin
    if (limit == '0) begin
      oldest = pos;
    end else if (fwd_q) begin
      oldest = fwd_data_q;
    end else begin
      oldest = ram_rdata;
    end
  end

  always_comb begin
    zeros_new = zeros_q;
    start_new = cur_start_q;
    if (is_zero) begin
      if (overflow) begin
        zeros_new = zcnt_t'(limit);
        start_new = oldest + 1'b1;
      end else begin
        zeros_new = zc_inc;
      end
    end
  end

  assign len       = pos + 1'b1 - start_new;
  // window may hold too many zeros after the limit was lowered mid-string
  assign take_best = (zeros_new <= zcnt_t'(limit)) && (len > best_len_q);

  assign best_len_new   = take_best ? len : best_len_q;
  assign best_start_new = take_best ? start_new : best_start_q;

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    max_zeros_d  = cfg_we_i ? cfg_wdata_i : max_zeros_q;
    head_d       = head_q;
    zeros_d      = zeros_q;
    cur_start_d  = cur_start_q;
    pos_cnt_d    = pos_cnt_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    out_valid_d  = out_valid_q && !win_o.ready;
    out_found_d  = out_found_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;

    if (in_fire) begin
      if (bit_i.last_bit) begin
        // end of string: emit result, clear string state
        head_d       = '0;
        zeros_d      = '0;
        cur_start_d  = pos_t'(1);
        pos_cnt_d    = '0;
        best_start_d = '0;
        best_len_d   = '0;
        out_valid_d  = 1'b1;
        out_found_d  = best_len_new != '0;
        if (best_len_new != '0) begin
          out_start_d = best_start_new;
          out_end_d   = best_start_new + best_len_new - 1'b1;
        end else begin
          out_start_d = '0;
          out_end_d   = '0;
        end
      end else begin
        head_d       = is_zero ? ring_next(head_q) : head_q;
        zeros_d      = zeros_new;
        cur_start_d  = start_new;
        pos_cnt_d    = pos;
        best_start_d = best_start_new;
        best_len_d   = best_len_new;
      end
    end
  end

  // Prefetch the slot that would leave on a zero next cycle.
  assign raddr = ring_back(head_d, limit_nx);
  assign fwd_d = is_zero && (head_q == raddr);

  // --------------------------------------------------------------------------
  // Zero position ring
  // --------------------------------------------------------------------------
  lowkz_ram #(
    .WIDTH (POSITION_BITS),
    .DEPTH (ZERO_RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (is_zero),
    .waddr_i (head_q),
    .wdata_i (pos),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_zeros_q  <= '0;
      head_q       <= '0;
      zeros_q      <= '0;
      cur_start_q  <= pos_t'(1);
      pos_cnt_q    <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      max_zeros_q  <= max_zeros_d;
      head_q       <= head_d;
      zeros_q      <= zeros_d;
      cur_start_q  <= cur_start_d;
      pos_cnt_q    <= pos_cnt_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      fwd_q        <= fwd_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q  <= pos;
    out_found_q <= out_found_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
  end

  assign win_o.valid        = out_valid_q;
  assign win_o.found        = out_found_q;
  assign win_o.window_start = out_start_q;
  assign win_o.window_end   = out_end_q;

endmodule
